### src/tka_pkg.sv
// shared widths, codes and helpers for the k-th ancestor lifting core
package tka_pkg;

  // payload widths
  localparam int NODE_W  = 11;
  localparam int VALUE_W = 11;
  localparam int KIND_W  = 2;

  // default sizing of the jump table
  localparam int MAX_NODES_DEF = 1024;
  localparam int LEVELS_DEF    = 11;

  // configuration port
  localparam int APB_DATA_W = 32;
  localparam int PADDR_W    = 3;

  // register index, taken from paddr[2]
  localparam logic REG_NODE_COUNT = 1'b0;
  localparam logic [NODE_W-1:0] NODE_COUNT_RST = NODE_W'(1);

  // item kinds
  localparam logic [KIND_W-1:0] KIND_SET   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_BUILD = 2'd1;
  localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

  // index of the lowest set bit of a step count
  function automatic logic [3:0] lsb_index(input logic [VALUE_W-1:0] x);
    logic [3:0] idx;
    idx = 4'd0;
    for (int i = VALUE_W - 1; i >= 0; i--) begin
      if (x[i]) idx = 4'(i);
    end
    return idx;
  endfunction

endpackage

### src/tka_if.sv
// valid/ready channel interfaces for items and results
interface tka_req_if;
  import tka_pkg::*;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0]  kind;
  logic [NODE_W-1:0]  node;
  logic [VALUE_W-1:0] value;
  modport source (output valid, kind, node, value, input ready);
  modport sink (input valid, kind, node, value, output ready);
  modport monitor (input valid, ready, kind, node, value);
endinterface

interface tka_rsp_if;
  import tka_pkg::*;
  logic              valid;
  logic              ready;
  logic [NODE_W-1:0] ancestor;
  logic              found;
  modport source (output valid, ancestor, found, input ready);
  modport sink (input valid, ancestor, found, output ready);
  modport monitor (input valid, ready, ancestor, found);
endinterface

### src/tree_kth_ancestor_lifting_core.sv
// k-th ancestor by binary lifting: one jump table ram walked by a small sequencer
// set parent: written to the table at the transfer; ready stays high
// query: one table read per set bit of k, the walk ending early when it leaves the tree;
// no read is needed for k of zero, a bad node or a step bit above the top level
// build: for each node and level, mid read, jump read, write; ready is low while busy
// rst clears control state and node_count to 1; the table is not cleared
module tree_kth_ancestor_lifting_core #(
  parameter int MAX_NODES = tka_pkg::MAX_NODES_DEF,
  parameter int LEVELS    = tka_pkg::LEVELS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  tka_req_if.sink                        req,
  tka_rsp_if.source                      rsp,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tka_pkg::PADDR_W-1:0]    paddr,
  input  logic [tka_pkg::APB_DATA_W-1:0] pwdata,
  output logic [tka_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);
  import tka_pkg::*;

  localparam int LEV_W     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int NIDX_W    = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int RAM_DEPTH = LEVELS * (2 ** NIDX_W);
  localparam int RAM_AW    = $clog2(RAM_DEPTH);
  localparam logic [NODE_W-1:0] MAX_CLAMP =
    (MAX_NODES >= 2047) ? NODE_W'(2047) : NODE_W'(MAX_NODES);
  localparam logic [VALUE_W-1:0] HIGH_MASK = VALUE_W'(~((32'd1 << LEVELS) - 32'd1));
  localparam logic [LEV_W-1:0] TOP_LEVEL = LEV_W'(LEVELS - 1);

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_BLD_MID = 7'b0000010,
    S_BLD_TOP = 7'b0000100,
    S_BLD_WR  = 7'b0001000,
    S_Q_ISSUE = 7'b0010000,
    S_Q_WAIT  = 7'b0100000,
    S_DONE    = 7'b1000000
  } state_t;

  state_t state, state_next;

  logic [NODE_W-1:0]  node_count;
  logic [NODE_W-1:0]  cnt;
  logic [LEV_W-1:0]   lev;
  logic [NODE_W-1:0]  vnode;
  logic [VALUE_W-1:0] rem;
  logic [NODE_W-1:0]  cur;
  logic [NODE_W-1:0]  res_anc;
  logic               res_found;
  logic               out_valid;
  logic [NODE_W-1:0]  out_anc;
  logic               out_found;

  logic               in_xfer;
  logic               out_load;
  logic               cfg_wr;
  logic               node_ok;
  logic               last_node;
  logic               last_level;

  logic [NODE_W-1:0]  rd_node;
  logic [LEV_W-1:0]   rd_level;
  logic [RAM_AW-1:0]  raddr;
  logic               rd_none;
  logic [NODE_W-1:0]  rdata;

  logic               we;
  logic [NODE_W-1:0]  wr_node;
  logic [LEV_W-1:0]   wr_level;
  logic [NODE_W-1:0]  wdata;
  logic [RAM_AW-1:0]  waddr;
  logic               wr_none;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_NODE_COUNT);
  assign prdata = (paddr[2] == REG_NODE_COUNT) ? APB_DATA_W'(node_count) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= NODE_COUNT_RST;
    end else if (cfg_wr) begin
      node_count <= pwdata[NODE_W-1:0];
    end
  end

  // nodes in use, clamped to 1..MAX_NODES
  always_comb begin
    if (node_count == '0) begin
      cnt = NODE_W'(1);
    end else if (node_count > MAX_CLAMP) begin
      cnt = MAX_CLAMP;
    end else begin
      cnt = node_count;
    end
  end

  // handshakes
  assign req.ready = (state == S_IDLE);
  assign in_xfer   = req.valid && req.ready;
  assign out_load  = (state == S_DONE) && (!out_valid || rsp.ready);
  assign node_ok   = (req.node != '0) && (req.node <= cnt);
  assign last_node  = (vnode == cnt);
  assign last_level = (lev == TOP_LEVEL);

  // read address source
  always_comb begin
    if ((state == S_BLD_TOP) || (state == S_Q_WAIT)) begin
      rd_node = rdata;
    end else if (state == S_BLD_MID) begin
      rd_node = vnode;
    end else begin
      rd_node = cur;
    end
    if ((state == S_BLD_MID) || (state == S_BLD_TOP)) begin
      rd_level = lev - LEV_W'(1);
    end else begin
      rd_level = LEV_W'(lsb_index(rem));
    end
  end

  tka_lift_unit #(
    .MAX_NODES (MAX_NODES),
    .LEVELS    (LEVELS)
  ) u_rd_lift (
    .node  (rd_node),
    .level (rd_level),
    .addr  (raddr),
    .none  (rd_none)
  );

  // write port source
  always_comb begin
    we       = 1'b0;
    wr_node  = vnode;
    wr_level = lev;
    wdata    = '0;
    if ((state == S_IDLE) && in_xfer && (req.kind == KIND_SET)) begin
      we       = node_ok;
      wr_node  = req.node;
      wr_level = '0;
      wdata    = (req.value <= cnt) ? req.value : '0;
    end else if ((state == S_BLD_TOP) && rd_none) begin
      we = 1'b1;
    end else if (state == S_BLD_WR) begin
      we    = 1'b1;
      wdata = rdata;
    end
  end

  tka_lift_unit #(
    .MAX_NODES (MAX_NODES),
    .LEVELS    (LEVELS)
  ) u_wr_lift (
    .node  (wr_node),
    .level (wr_level),
    .addr  (waddr),
    .none  (wr_none)
  );

  tka_ram #(
    .WIDTH (NODE_W),
    .DEPTH (RAM_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (we && !wr_none),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_xfer) begin
          if ((req.kind == KIND_BUILD) && (LEVELS > 1)) begin
            state_next = S_BLD_MID;
          end else if (req.kind == KIND_QUERY) begin
            if (!node_ok || ((req.value & HIGH_MASK) != '0) || (req.value == '0)) begin
              state_next = S_DONE;
            end else begin
              state_next = S_Q_ISSUE;
            end
          end
        end
      end
      S_BLD_MID: begin
        state_next = S_BLD_TOP;
      end
      S_BLD_TOP: begin
        if (!rd_none) begin
          state_next = S_BLD_WR;
        end else if (last_node && last_level) begin
          state_next = S_IDLE;
        end else begin
          state_next = S_BLD_MID;
        end
      end
      S_BLD_WR: begin
        if (last_node && last_level) begin
          state_next = S_IDLE;
        end else begin
          state_next = S_BLD_MID;
        end
      end
      S_Q_ISSUE: begin
        state_next = S_Q_WAIT;
      end
      S_Q_WAIT: begin
        if (rd_none || (rem == '0)) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // build counters, query walk and pending result
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        lev   <= LEV_W'(1);
        vnode <= NODE_W'(1);
        cur   <= req.node;
        rem   <= req.value;
        if (!node_ok || ((req.value & HIGH_MASK) != '0)) begin
          res_anc   <= '0;
          res_found <= 1'b0;
        end else begin
          res_anc   <= req.node;
          res_found <= 1'b1;
        end
      end
      S_BLD_TOP, S_BLD_WR: begin
        if ((state == S_BLD_WR) || rd_none) begin
          if (last_node) begin
            vnode <= NODE_W'(1);
            lev   <= lev + LEV_W'(1);
          end else begin
            vnode <= vnode + NODE_W'(1);
          end
        end
      end
      S_Q_ISSUE: begin
        rem <= rem & (rem - VALUE_W'(1));
      end
      S_Q_WAIT: begin
        rem <= rem & (rem - VALUE_W'(1));
        if (rd_none) begin
          res_anc   <= '0;
          res_found <= 1'b0;
        end else begin
          res_anc   <= rdata;
          res_found <= 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_anc   <= res_anc;
      out_found <= res_found;
    end
  end

  assign rsp.valid    = out_valid;
  assign rsp.ancestor = out_anc;
  assign rsp.found    = out_found;

endmodule

### src/tka_ram.sv
// generic simple dual-port ram with registered read
module tka_ram #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 1024
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/tka_lift_unit.sv
// maps a node and a table level to a jump table address
module tka_lift_unit #(
  parameter int MAX_NODES = 1024,
  parameter int LEVELS    = 11
) (
  input  logic [tka_pkg::NODE_W-1:0] node,
  input  logic [((LEVELS > 1) ? $clog2(LEVELS) : 1)-1:0] level,
  output logic [$clog2(LEVELS * (2 ** ((MAX_NODES > 1) ? $clog2(MAX_NODES) : 1)))-1:0] addr,
  output logic              none
);
  import tka_pkg::*;

  localparam int NIDX_W  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int RAM_AW  = $clog2(LEVELS * (2 ** NIDX_W));

  logic [NODE_W-1:0] node_m1;

  // level selects the bank, node minus one the row
  assign node_m1 = node - NODE_W'(1);
  assign addr    = RAM_AW'({level, NIDX_W'(node_m1)});
  assign none    = (node == '0);

endmodule

### src/tka_checker.sv
// port-level checks for the k-th ancestor lifting core, bound to the top level
module tka_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       req_valid,
  input logic                       req_ready,
  input logic [tka_pkg::KIND_W-1:0] req_kind,
  input logic                       rsp_valid,
  input logic                       rsp_ready,
  input logic [tka_pkg::NODE_W-1:0] rsp_ancestor,
  input logic                       rsp_found
);
  import tka_pkg::*;

  // a stalled result stays offered
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result dropped while stalled");

  // a miss always reports node zero
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_found |-> rsp_ancestor == '0)
    else $error("miss with non-zero ancestor");

  // a hit never reports node zero
  a_hit_nonzero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_found |-> rsp_ancestor != '0)
    else $error("hit on node zero");

  // a query keeps the block busy for the next cycle
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && (req_kind == KIND_QUERY) |=> !req_ready)
    else $error("ready right after a query transfer");

  // reset empties the result register
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result pending after reset");

endmodule

bind tree_kth_ancestor_lifting_core tka_checker u_tka_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .req_kind     (req.kind),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .rsp_ancestor (rsp.ancestor),
  .rsp_found    (rsp.found)
);

### sim/tka_tb_pkg.sv
// expected-answer tracking for the k-th ancestor lifting core testbench
package tka_tb_pkg;
  import tka_pkg::*;

  // item kind that the core ignores
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
  // byte address of the node count register
  localparam logic [PADDR_W-1:0] ADDR_NODE_COUNT = {REG_NODE_COUNT, 2'b00};

  localparam int TABLE_NODES = MAX_NODES_DEF;
  localparam int LIFT_LEVELS = LEVELS_DEF;

  typedef struct packed {
    logic [NODE_W-1:0] ancestor;
    logic              found;
  } answer_t;

  class ancestor_checker;
    logic [NODE_W-1:0] jump [TABLE_NODES][LIFT_LEVELS];
    logic [NODE_W-1:0] node_count;
    answer_t           pending_answers[$];
    int unsigned       mismatches;
    int unsigned       answers_seen;
    int unsigned       found_seen;

    function new();
      foreach (jump[i, j]) jump[i][j] = '0;
      node_count   = NODE_COUNT_RST;
      mismatches   = 0;
      answers_seen = 0;
      found_seen   = 0;
    endfunction

    function void write_node_count(logic [NODE_W-1:0] v);
      node_count = v;
    endfunction

    // zero acts as one node, anything above the table size as the full table
    function int unsigned active_nodes();
      if (node_count == 0) return 1;
      if (node_count > TABLE_NODES) return TABLE_NODES;
      return node_count;
    endfunction

    function int unsigned pending();
      return pending_answers.size();
    endfunction

    // each level from the one below: 2^j up is 2^(j-1) up from the node 2^(j-1) up
    function void build_levels();
      int unsigned cnt;
      logic [NODE_W-1:0] mid;
      cnt = active_nodes();
      for (int lev = 1; lev < LIFT_LEVELS; lev++) begin
        for (int v = 1; v <= cnt; v++) begin
          mid = jump[v-1][lev-1];
          jump[v-1][lev] = (mid != 0) ? jump[mid-1][lev-1] : '0;
        end
      end
    endfunction

    // update table state for one transfer, queue an answer for queries
    function void apply_item(logic [KIND_W-1:0] kind, logic [NODE_W-1:0] node,
                             logic [VALUE_W-1:0] value);
      int unsigned cnt;
      logic [NODE_W-1:0] cur;
      bit ok;
      answer_t ans;
      cnt = active_nodes();
      case (kind)
        KIND_SET: begin
          if (node >= 1 && node <= cnt) jump[node-1][0] = (value <= cnt) ? value : '0;
        end
        KIND_BUILD: begin
          build_levels();
        end
        KIND_QUERY: begin
          cur = node;
          ok  = (node >= 1 && node <= cnt);
          for (int b = 0; b < VALUE_W; b++) begin
            if (ok && value[b]) begin
              if (b >= LIFT_LEVELS) begin
                ok = 1'b0;
              end else begin
                cur = jump[cur-1][b];
                if (cur == 0) ok = 1'b0;
              end
            end
          end
          ans.ancestor = ok ? cur : '0;
          ans.found    = ok;
          pending_answers = {pending_answers, ans};
        end
        default: ;
      endcase
    endfunction

    task report(string what, logic [NODE_W-1:0] want, logic [NODE_W-1:0] got);
      if (mismatches < 30)
        $display("mismatch %0d: %s expected %0d got %0d", mismatches + 1, what, want, got);
      mismatches++;
    endtask

    // compare one result transfer with the oldest queued answer
    task check_answer(logic [NODE_W-1:0] ancestor, logic found);
      answer_t want;
      answers_seen++;
      if (pending_answers.size() == 0) begin
        report("result with nothing queued, ancestor", '0, ancestor);
        return;
      end
      want = pending_answers.pop_front();
      if (want.found) found_seen++;
      if (ancestor !== want.ancestor) report("ancestor", want.ancestor, ancestor);
      if (found !== want.found) report("found", want.found, found);
    endtask
  endclass

endpackage

### sim/tb_top.sv
// top-level testbench for the k-th ancestor lifting core
module tb_top;
  import tka_pkg::*;
  import tka_tb_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 2_000_000;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned RANDOM_ITEMS = 520;

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [PADDR_W-1:0]    paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  tka_req_if req_ch();
  tka_rsp_if rsp_ch();

  ancestor_checker sb;
  int unsigned     cycles        = 0;
  int unsigned     burst_left    = 0;
  int unsigned     items_sent    = 0;
  int unsigned     settings_run  = 0;
  bit              gaps_on       = 1'b1;
  bit              long_hold_due = 1'b0;

  tree_kth_ancestor_lifting_core u_dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
  end

  // watchdog
  initial begin
    while (cycles < CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles", cycles);
    $display("FAIL tree_kth_ancestor_lifting_core");
    $finish;
  end

  // result transfers go to the checker
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) sb.check_answer(rsp_ch.ancestor, rsp_ch.found);
  end

  // receiver: stall pattern that changes mode now and then, plus the long hold-off
  initial begin
    int unsigned mode_left;
    int unsigned hold_left;
    int unsigned mode;
    int unsigned beat;
    mode_left = 0;
    hold_left = 0;
    mode      = 0;
    beat      = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_due) begin
        long_hold_due = 1'b0;
        hold_left     = LONG_HOLD;
      end
      @(negedge clk);
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 120);
      end
      mode_left--;
      beat++;
      if (hold_left != 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        case (mode)
          0: rsp_ch.ready <= 1'b1;
          1: rsp_ch.ready <= 1'($urandom_range(0, 1));
          2: rsp_ch.ready <= (beat % 4 == 0);
          default: rsp_ch.ready <= (beat % 3 != 0);
        endcase
      end
    end
  end

  // drop valid and stay quiet for the gap given by n
  task idle_sender(int unsigned n);
    req_ch.valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // offer one item until its transfer, then maybe open a gap; returns at a falling edge
  task send_item(logic [KIND_W-1:0] kind, logic [NODE_W-1:0] node, logic [VALUE_W-1:0] value);
    req_ch.valid <= 1'b1;
    req_ch.kind  <= kind;
    req_ch.node  <= node;
    req_ch.value <= value;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sb.apply_item(kind, node, value);
    if (kind != KIND_SPARE) items_sent++;
    @(negedge clk);
    if (gaps_on) begin
      if (burst_left <= 1) begin
        burst_left = $urandom_range(1, 16);
        idle_sender($urandom_range(1, 8));
      end else begin
        burst_left--;
      end
    end
  endtask

  // wait until every queued answer has arrived
  task drain();
    idle_sender(0);
    while (sb.pending() != 0) @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  // write node_count with junk in the upper bits, then read it back
  task write_node_count(logic [NODE_W-1:0] cnt);
    logic [APB_DATA_W-1:0] data;
    data = ($urandom() & ~APB_DATA_W'(2047)) | APB_DATA_W'(cnt);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_NODE_COUNT;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.write_node_count(cnt);
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[NODE_W-1:0] !== cnt) sb.report("node_count readback", cnt, prdata[NODE_W-1:0]);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // parents for nodes 1..n: a chain, a bushy deep tree, or wild links with cycles
  task load_tree(int unsigned n, int unsigned style);
    int unsigned parent;
    int unsigned span;
    for (int unsigned v = 1; v <= n; v++) begin
      case (style)
        0: parent = v - 1;
        1: begin
          span   = (v - 1 < 3) ? v - 1 : 3;
          parent = (v == 1 || $urandom_range(0, 9) == 0) ? 0 : v - $urandom_range(1, span);
        end
        default: parent = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2047)
                                                      : $urandom_range(0, n);
      endcase
      send_item(KIND_SET, NODE_W'(v), VALUE_W'(parent));
    end
  endtask

  // query mostly on live nodes, with a spread of step counts
  task random_query(int unsigned n);
    int unsigned node;
    int unsigned k;
    case ($urandom_range(0, 19))
      17: node = 0;
      18: node = $urandom_range(n + 1, 2047);
      19: node = 2047;
      default: node = $urandom_range(1, n);
    endcase
    case ($urandom_range(0, 9))
      0, 1, 2: k = $urandom_range(0, 7);
      3, 4, 5: k = $urandom_range(0, n);
      6, 7: k = 1 << $urandom_range(0, 10);
      8: k = $urandom_range(0, 2047);
      default: k = $urandom_range(0, 1) ? 0 : 2047;
    endcase
    send_item(KIND_QUERY, NODE_W'(node), VALUE_W'(k));
  endtask

  task mixed_item(int unsigned n);
    int unsigned pick;
    int unsigned node;
    int unsigned parent;
    pick = $urandom_range(0, 99);
    if (pick < 74 || (pick >= 88 && pick < 94 && n > 64)) begin
      random_query(n);
    end else if (pick < 88) begin
      node   = ($urandom_range(0, 9) != 0) ? $urandom_range(1, n) : $urandom_range(0, 2047);
      parent = ($urandom_range(0, 3) != 0) ? $urandom_range(0, n) : $urandom_range(0, 2047);
      send_item(KIND_SET, NODE_W'(node), VALUE_W'(parent));
    end else if (pick < 94) begin
      send_item(KIND_BUILD, NODE_W'($urandom_range(0, 2047)), VALUE_W'($urandom_range(0, 2047)));
    end else begin
      send_item(KIND_SPARE, NODE_W'($urandom_range(0, 2047)), VALUE_W'($urandom_range(0, 2047)));
    end
  endtask

  // one node_count setting: load, build, mixed traffic, close with a query and drain
  task run_setting(logic [NODE_W-1:0] cnt, bit reload, int unsigned mix, bit pressure);
    int unsigned n;
    write_node_count(cnt);
    n = sb.active_nodes();
    gaps_on = ($urandom_range(0, 3) != 0);
    if (reload) load_tree(n, $urandom_range(0, 2));
    send_item(KIND_BUILD, NODE_W'($urandom_range(0, 2047)), VALUE_W'($urandom_range(0, 2047)));
    for (int unsigned i = 0; i < mix; i++) begin
      if (pressure && i == mix / 4) long_hold_due = 1'b1;
      if (pressure && i == mix / 2) drain();
      mixed_item(n);
    end
    random_query(n);
    drain();
    settings_run++;
  endtask

  // stimulus
  initial begin
    int unsigned random_start;
    rst          = 1'b1;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    req_ch.valid = 1'b0;
    req_ch.kind  = KIND_SET;
    req_ch.node  = '0;
    req_ch.value = '0;
    sb = new();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset node count of one: no table reads needed
    send_item(KIND_QUERY, NODE_W'(1), VALUE_W'(0));
    send_item(KIND_QUERY, NODE_W'(2), VALUE_W'(0));
    drain();

    // small hand-built tree: chain 3-2-1, node 4 first a root, 5 and 6 in a cycle
    write_node_count(NODE_W'(6));
    send_item(KIND_SET, NODE_W'(0), VALUE_W'(1));
    send_item(KIND_SET, NODE_W'(7), VALUE_W'(1));
    send_item(KIND_SET, NODE_W'(2047), VALUE_W'(3));
    send_item(KIND_SPARE, NODE_W'(1), VALUE_W'(5));
    send_item(KIND_SET, NODE_W'(1), VALUE_W'(0));
    send_item(KIND_SET, NODE_W'(2), VALUE_W'(1));
    send_item(KIND_SET, NODE_W'(3), VALUE_W'(2));
    send_item(KIND_SET, NODE_W'(4), VALUE_W'(2047));
    send_item(KIND_SET, NODE_W'(5), VALUE_W'(6));
    send_item(KIND_SET, NODE_W'(6), VALUE_W'(5));
    send_item(KIND_QUERY, NODE_W'(4), VALUE_W'(1));
    send_item(KIND_QUERY, NODE_W'(3), VALUE_W'(0));
    send_item(KIND_SET, NODE_W'(4), VALUE_W'(3));
    send_item(KIND_BUILD, NODE_W'(0), VALUE_W'(0));
    send_item(KIND_QUERY, NODE_W'(4), VALUE_W'(3));
    send_item(KIND_QUERY, NODE_W'(4), VALUE_W'(4));
    send_item(KIND_QUERY, NODE_W'(4), VALUE_W'(0));
    send_item(KIND_QUERY, NODE_W'(5), VALUE_W'(2047));
    send_item(KIND_QUERY, NODE_W'(6), VALUE_W'(1024));
    send_item(KIND_QUERY, NODE_W'(0), VALUE_W'(1));
    send_item(KIND_QUERY, NODE_W'(2047), VALUE_W'(0));
    send_item(KIND_QUERY, NODE_W'(1), VALUE_W'(1));
    send_item(KIND_QUERY, NODE_W'(2), VALUE_W'(1));
    drain();

    // smallest node_count settings
    run_setting(NODE_W'(0), 1'b1, 20, 1'b0);
    run_setting(NODE_W'(1), 1'b1, 20, 1'b0);

    // node_count above the table acts as the full table; only level-0 links are walked
    write_node_count(NODE_W'(2047));
    send_item(KIND_SET, NODE_W'(1024), VALUE_W'(1023));
    send_item(KIND_SET, NODE_W'(1023), VALUE_W'(1024));
    send_item(KIND_SET, NODE_W'(1025), VALUE_W'(1));
    send_item(KIND_SET, NODE_W'(1022), VALUE_W'(1025));
    send_item(KIND_QUERY, NODE_W'(1024), VALUE_W'(1));
    send_item(KIND_QUERY, NODE_W'(1023), VALUE_W'(1));
    send_item(KIND_QUERY, NODE_W'(1022), VALUE_W'(1));
    send_item(KIND_QUERY, NODE_W'(1024), VALUE_W'(0));
    send_item(KIND_QUERY, NODE_W'(1025), VALUE_W'(0));
    send_item(KIND_QUERY, NODE_W'(1025), VALUE_W'(1));
    drain();
    write_node_count(NODE_W'(1024));
    send_item(KIND_SET, NODE_W'(1024), VALUE_W'(1024));
    send_item(KIND_QUERY, NODE_W'(1024), VALUE_W'(1));
    send_item(KIND_QUERY, NODE_W'(1023), VALUE_W'(1));
    send_item(KIND_QUERY, NODE_W'(1025), VALUE_W'(0));
    drain();

    // random settings, mostly small trees
    random_start = items_sent;
    run_setting(NODE_W'($urandom_range(8, 40)), 1'b1, 80, 1'b1);
    while (items_sent - random_start < RANDOM_ITEMS) begin
      run_setting(($urandom_range(0, 5) == 0) ? NODE_W'($urandom_range(49, 200))
                                              : NODE_W'($urandom_range(2, 48)),
                  1'b1, $urandom_range(30, 70), 1'b0);
    end

    idle_sender(0);
    while (sb.pending() != 0) @(negedge clk);
    repeat (48) @(negedge clk);

    $display("covered %0d items over %0d node_count settings in %0d cycles",
             items_sent, settings_run, cycles);
    $display("checked %0d answers: %0d found, %0d left the tree; %0d mismatches",
             sb.answers_seen, sb.found_seen, sb.answers_seen - sb.found_seen, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("PASS tree_kth_ancestor_lifting_core");
    end else begin
      $display("FAIL tree_kth_ancestor_lifting_core");
    end
    $finish;
  end

endmodule
